FILE: hdl/ordered_array_list_unit_macros.svh
// Assertion macros shared by the ordered array list RTL.
// No dependencies; the including module provides the clock and reset names.
`ifndef ORDERED_ARRAY_LIST_UNIT_MACROS_SVH
`define ORDERED_ARRAY_LIST_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define OAL_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define OAL_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/oal_pkg.sv
// Package for the ordered array list: field widths, codes and cell control.
// No dependencies.
`default_nettype none

package oal_pkg;

    localparam int FUNC_W = 3;
    localparam int POS_W  = 4;
    localparam int VAL_W  = 32;
    localparam int FIDX_W = 4;
    localparam int LEN_W  = 5;
    localparam int CAP_W  = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [FUNC_W-1:0] {
        FN_INS_BEFORE = 3'd0,
        FN_INS_AFTER  = 3'd1,
        FN_APPEND     = 3'd2,
        FN_DELETE     = 3'd3,
        FN_READ       = 3'd4,
        FN_FIND       = 3'd5,
        FN_CLEAR      = 3'd6
    } func_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_INDEX = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD  = 2'd0,
        CELL_OPEN  = 2'd1,
        CELL_CLOSE = 2'd2,
        CELL_FIND  = 2'd3
    } cell_op_t;

    // per-cell control, decoded by the top level from the cell's index
    typedef struct packed {
        cell_op_t op;
        logic     at;     // cell index equals the operation index
        logic     above;  // cell index is above the operation index
        logic     live;   // cell index is below the current length
    } cell_ctl_t;

endpackage

`default_nettype wire

FILE: hdl/oal_cell.sv
// One storage cell of the ordered array list chain: element register and match flag.
// Depends on oal_pkg.
`default_nettype none

module oal_cell #(
    parameter int ELEM_WIDTH = 32
) (
    input  wire logic                  clk,
    input  wire oal_pkg::cell_ctl_t    ctl,
    input  wire logic [ELEM_WIDTH-1:0] data_lo,   // from the cell below
    input  wire logic [ELEM_WIDTH-1:0] data_hi,   // from the cell above
    input  wire logic [ELEM_WIDTH-1:0] operand,
    output logic      [ELEM_WIDTH-1:0] data,
    output logic                       match
);
    import oal_pkg::*;

    logic [ELEM_WIDTH-1:0] data_reg, data_next;
    logic                  match_reg, match_next;

    always_comb
    begin
        data_next  = data_reg;
        match_next = match_reg;
        case (ctl.op)
            CELL_OPEN:
            begin
                if (ctl.above)
                begin
                    data_next = data_lo;
                end
                else if (ctl.at)
                begin
                    data_next = operand;
                end
            end
            CELL_CLOSE:
            begin
                if (ctl.at || ctl.above)
                begin
                    data_next = data_hi;
                end
            end
            CELL_FIND:
            begin
                match_next = ctl.live && (data_reg == operand);
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg  <= data_next;
        match_reg <= match_next;
    end

    assign data  = data_reg;
    assign match = match_reg;

endmodule

`default_nettype wire

FILE: hdl/ordered_array_list_unit.sv
// Top level of the ordered array list: command decode, length and capacity, cell chain.
// Depends on oal_pkg, oal_cell and ordered_array_list_unit_macros.svh.
`default_nettype none

// Ordered list of up to DEPTH elements held in a chain of cells, one element per
// cell. A command transfer happens on a clock edge with start high and busy low.
// Inserts, appends, deletes, reads and clears finish on that edge: every cell
// moves, takes the new value or holds in parallel, and the result is presented on
// the next cycle with done high. Find first latches a compare flag in every cell,
// then picks the lowest matching index while busy is high. Throughput is one
// command per cycle while busy is low; a find holds busy high, so no new command
// is taken until its result is registered. done lasts exactly one cycle and cannot
// be held off, so the receiver must take each result transfer as it appears. The
// capacity register may be written at any time the block is idle; the full check
// uses the smaller of the capacity and DEPTH.
module ordered_array_list_unit #(
    parameter int DEPTH      = 16,
    parameter int ELEM_WIDTH = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // configuration
    input  wire logic [oal_pkg::CAP_W-1:0]     cfg_wr_data,
    input  wire logic                          cfg_wr_en,
    // command
    input  wire logic                          start,
    input  wire logic [oal_pkg::FUNC_W-1:0]    func,
    input  wire logic [oal_pkg::POS_W-1:0]     position,
    input  wire logic signed [oal_pkg::VAL_W-1:0] operand_value,
    output logic                               busy,
    // result
    output logic                               done,
    output logic [1:0]                         status,
    output logic signed [oal_pkg::VAL_W-1:0]   result_value,
    output logic [oal_pkg::FIDX_W-1:0]         found_index,
    output logic [oal_pkg::LEN_W-1:0]          list_length
);
    import oal_pkg::*;
    `include "ordered_array_list_unit_macros.svh"

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    // control registers
    logic [CAP_W-1:0]  capacity_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              find_pend_reg, find_pend_next;
    // result registers
    logic              done_reg, done_next;
    status_t           status_reg, status_next;
    logic [VAL_W-1:0]  rval_reg, rval_next;
    logic [FIDX_W-1:0] fidx_reg, fidx_next;
    logic [LEN_W-1:0]  len_reg, len_next;

    logic                  accept;
    logic [CMP_W-1:0]      pos_ext, count_ext, cap_ext, at_pos;
    logic                  pos_ok, full;
    logic [ELEM_WIDTH-1:0] operand_e, rd_elem;
    cell_op_t              cell_op;
    logic                  any_hit;
    logic [FIDX_W-1:0]     hit_idx;

    cell_ctl_t             cell_ctl  [DEPTH];
    logic [ELEM_WIDTH-1:0] cell_data [DEPTH];
    logic [DEPTH-1:0]      cell_match;

    assign accept    = start && !busy;
    assign pos_ext   = CMP_W'(position);
    assign count_ext = CMP_W'(count_reg);
    assign cap_ext   = CMP_W'(capacity_reg);
    // operand is taken as raw bits, zero-extended or cut to the element width
    assign operand_e = ELEM_WIDTH'($unsigned(operand_value));
    assign pos_ok    = pos_ext < count_ext;
    // count >= min(capacity, DEPTH)
    assign full      = (count_ext >= cap_ext) || (count_ext >= CMP_W'(DEPTH));

    // configuration write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
        end
        else if (cfg_wr_en)
        begin
            capacity_reg <= cfg_wr_data;
        end
    end

    // element at the requested position, for read and delete
    always_comb
    begin
        rd_elem = '0;
        for (int k = 0; k < DEPTH; k++)
        begin
            if (CMP_W'(k) == pos_ext)
            begin
                rd_elem = cell_data[k];
            end
        end
    end

    // lowest matching cell from the flags latched on the find edge
    always_comb
    begin
        any_hit = 1'b0;
        hit_idx = '0;
        for (int k = DEPTH - 1; k >= 0; k--)
        begin
            if (cell_match[k])
            begin
                any_hit = 1'b1;
                hit_idx = FIDX_W'(k);
            end
        end
    end

    // command decode
    always_comb
    begin
        count_next     = count_reg;
        find_pend_next = 1'b0;
        done_next      = 1'b0;
        status_next    = ST_OK;
        rval_next      = '0;
        fidx_next      = '0;
        cell_op        = CELL_HOLD;
        at_pos         = pos_ext;
        if (find_pend_reg)
        begin
            done_next = 1'b1;
            if (any_hit)
            begin
                fidx_next = hit_idx;
            end
            else
            begin
                status_next = ST_NOT_FOUND;
            end
        end
        else if (accept)
        begin
            done_next = 1'b1;
            case (func_t'(func))
                FN_INS_BEFORE, FN_INS_AFTER:
                begin
                    // index check comes before the full check
                    if (!pos_ok)
                    begin
                        status_next = ST_BAD_INDEX;
                    end
                    else if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        cell_op    = CELL_OPEN;
                        at_pos     = (func_t'(func) == FN_INS_AFTER) ? pos_ext + 1'b1 : pos_ext;
                        count_next = count_reg + 1'b1;
                    end
                end
                FN_APPEND:
                begin
                    if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        cell_op    = CELL_OPEN;
                        at_pos     = count_ext;
                        count_next = count_reg + 1'b1;
                    end
                end
                FN_DELETE:
                begin
                    if (!pos_ok)
                    begin
                        status_next = ST_BAD_INDEX;
                    end
                    else
                    begin
                        cell_op    = CELL_CLOSE;
                        rval_next  = VAL_W'(rd_elem);
                        count_next = count_reg - 1'b1;
                    end
                end
                FN_READ:
                begin
                    if (!pos_ok)
                    begin
                        status_next = ST_BAD_INDEX;
                    end
                    else
                    begin
                        rval_next = VAL_W'(rd_elem);
                    end
                end
                FN_FIND:
                begin
                    done_next      = 1'b0;
                    find_pend_next = 1'b1;
                    cell_op        = CELL_FIND;
                end
                FN_CLEAR:
                begin
                    count_next = '0;
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end
        len_next = LEN_W'(count_next);
    end

    // per-cell control from the cell's own index
    always_comb
    begin
        for (int k = 0; k < DEPTH; k++)
        begin
            cell_ctl[k].op    = cell_op;
            cell_ctl[k].at    = CMP_W'(k) == at_pos;
            cell_ctl[k].above = CMP_W'(k) > at_pos;
            cell_ctl[k].live  = CMP_W'(k) < count_ext;
        end
    end

    // cell chain: both neighbours per cell; operand below cell 0, top cell folds back
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        oal_cell #(
            .ELEM_WIDTH (ELEM_WIDTH)
        ) u_cell (
            .clk     (clk),
            .ctl     (cell_ctl[g]),
            .data_lo ((g == 0) ? operand_e : cell_data[(g == 0) ? 0 : g - 1]),
            .data_hi ((g == DEPTH - 1) ? cell_data[g] : cell_data[(g == DEPTH - 1) ? g : g + 1]),
            .operand (operand_e),
            .data    (cell_data[g]),
            .match   (cell_match[g])
        );
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            find_pend_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            find_pend_reg <= find_pend_next;
            done_reg      <= done_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        rval_reg   <= rval_next;
        fidx_reg   <= fidx_next;
        len_reg    <= len_next;
    end

    assign busy         = find_pend_reg;
    assign done         = done_reg;
    assign status       = status_reg;
    assign result_value = rval_reg;
    assign found_index  = fidx_reg;
    assign list_length  = len_reg;

    `OAL_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_ext <= CMP_W'(DEPTH),
        "length exceeds store depth")
    `OAL_ASSERT_NEXT(a_single_done, clk, rst_n,
        accept && (func_t'(func) != FN_FIND), done && !busy,
        "one-edge command gave no result")
    `OAL_ASSERT_NEXT(a_find_two_step, clk, rst_n,
        accept && (func_t'(func) == FN_FIND), busy && !done && $stable(count_reg),
        "find did not hold for its encode cycle")
    `OAL_ASSERT_NEXT(a_find_result, clk, rst_n, busy, done && !busy,
        "find result missing after encode cycle")

endmodule

`default_nettype wire
